[src/tpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared widths and types for the three-plane intersection pipeline.
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int PROD_W    = 2 * IN_W;
    localparam int SQ_W      = PROD_W + 2;
    localparam int CR_W      = PROD_W + 1;
    localparam int PP_W      = IN_W + 1 + IN_W + 1;
    localparam int S_W       = 98;
    localparam int DET_W     = 98;
    localparam int NUM_W     = 162;
    localparam int DEN_W     = DET_W + FRAC_BITS;
    localparam int QB        = 32;
    localparam int REM_W     = DEN_W + QB;
    localparam int THR_W     = 32;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2814750);

    // Control that travels beside a coordinate through the divider.
    typedef struct packed {
        logic valid;
        logic found;
        logic neg;
    } t_div_ctl;

endpackage

[src/three_plane_intersection_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_plane_intersection_top
// Intersection point of three planes by Cramer's rule, in fixed point.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; busy is always low, since the datapath is a
// pure pipeline and the receiver cannot stall it.
// Reset (synchronous, active low) clears every valid bit and loads the
// singular threshold with its default; data registers are not reset, except the divider outputs.
// ----------------------------------------------------------------------------
module three_plane_intersection_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpi_pkg::THR_W-1:0]      i_cfg_data,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane1_nx,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane1_ny,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane1_nz,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane1_dist,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane2_nx,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane2_ny,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane2_nz,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane2_dist,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane3_nx,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane3_ny,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane3_nz,
    input  logic signed [tpi_pkg::IN_W-1:0] i_plane3_dist,
    output logic                           o_valid,
    output logic signed [tpi_pkg::QB-1:0]  o_point_x,
    output logic signed [tpi_pkg::QB-1:0]  o_point_y,
    output logic signed [tpi_pkg::QB-1:0]  o_point_z,
    output logic                           o_found,
    output logic                           o_overflowed
);
    import tpi_pkg::*;

    // The word is taken whenever start is high; the pipeline never fills up.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic [THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // Stage 1: capture the word. Plane p has normal r1_n[p] and scale r1_d[p].
    logic                     r1_v;
    logic signed [IN_W-1:0]   r1_n [3][3];
    logic signed [IN_W-1:0]   r1_d [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start;
        end
        r1_n[0][0] <= i_plane1_nx; r1_n[0][1] <= i_plane1_ny; r1_n[0][2] <= i_plane1_nz;
        r1_n[1][0] <= i_plane2_nx; r1_n[1][1] <= i_plane2_ny; r1_n[1][2] <= i_plane2_nz;
        r1_n[2][0] <= i_plane3_nx; r1_n[2][1] <= i_plane3_ny; r1_n[2][2] <= i_plane3_nz;
        r1_d[0] <= i_plane1_dist;
        r1_d[1] <= i_plane2_dist;
        r1_d[2] <= i_plane3_dist;
    end

    // Stage 2: all 32x32 products. r2_cp[i][k] holds the two products of
    // cofactor component k, where cofactor i is n[i+1] x n[i+2].
    logic                     r2_v;
    logic signed [PROD_W-1:0] r2_sqp [3][3];
    logic signed [PROD_W-1:0] r2_cp  [3][3][2];
    logic signed [IN_W-1:0]   r2_n0  [3];
    logic signed [IN_W-1:0]   r2_d   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                r2_sqp[p][k]   <= r1_n[p][k] * r1_n[p][k];
                r2_cp[p][k][0] <= r1_n[(p+1)%3][(k+1)%3] * r1_n[(p+2)%3][(k+2)%3];
                r2_cp[p][k][1] <= r1_n[(p+1)%3][(k+2)%3] * r1_n[(p+2)%3][(k+1)%3];
            end
            r2_n0[p] <= r1_n[0][p];
            r2_d[p]  <= r1_d[p];
        end
    end

    // Stage 3: squared norms and cofactors.
    logic                     r3_v;
    logic signed [SQ_W-1:0]   r3_sq [3];
    logic signed [CR_W-1:0]   r3_c  [3][3];
    logic signed [IN_W-1:0]   r3_n0 [3];
    logic signed [IN_W-1:0]   r3_d  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        for (int p = 0; p < 3; p++) begin
            r3_sq[p] <= SQ_W'(r2_sqp[p][0]) + SQ_W'(r2_sqp[p][1]) + SQ_W'(r2_sqp[p][2]);
            for (int k = 0; k < 3; k++) begin
                r3_c[p][k] <= CR_W'(r2_cp[p][k][0]) - CR_W'(r2_cp[p][k][1]);
            end
            r3_n0[p] <= r2_n0[p];
            r3_d[p]  <= r2_d[p];
        end
    end

    // Stage 4: wide products split at bit 32. The squared norm is never
    // negative and fits 64 bits, so both of its halves are unsigned.
    logic                     r4_v;
    logic signed [PP_W-1:0]   r4_sl [3];
    logic signed [PP_W-1:0]   r4_sh [3];
    logic signed [PP_W-1:0]   r4_dl [3];
    logic signed [PP_W-1:0]   r4_dh [3];
    logic signed [CR_W-1:0]   r4_c  [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        for (int p = 0; p < 3; p++) begin
            r4_sl[p] <= PP_W'(r3_d[p] * $signed({1'b0, r3_sq[p][31:0]}));
            r4_sh[p] <= PP_W'(r3_d[p] * $signed({1'b0, r3_sq[p][63:32]}));
            r4_dl[p] <= PP_W'(r3_n0[p] * $signed({1'b0, r3_c[0][p][31:0]}));
            r4_dh[p] <= PP_W'(r3_n0[p] * $signed(r3_c[0][p][CR_W-1:32]));
            for (int k = 0; k < 3; k++) begin
                r4_c[p][k] <= r3_c[p][k];
            end
        end
    end

    // Stage 5: right-hand sides and the determinant.
    logic                     r5_v;
    logic signed [S_W-1:0]    r5_s [3];
    logic signed [DET_W-1:0]  r5_det;
    logic signed [CR_W-1:0]   r5_c [3][3];
    logic signed [DET_W-1:0]  n_det;

    always_comb begin
        n_det = '0;
        for (int k = 0; k < 3; k++) begin
            n_det = n_det + (DET_W'(r4_dh[k]) <<< 32) + DET_W'(r4_dl[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        for (int p = 0; p < 3; p++) begin
            r5_s[p] <= (S_W'(r4_sh[p]) <<< 32) + S_W'(r4_sl[p]);
            for (int k = 0; k < 3; k++) begin
                r5_c[p][k] <= r4_c[p][k];
            end
        end
        r5_det <= n_det;
    end

    // Stage 6: numerator partial products (s in three pieces, cofactor in
    // two), plus the singular test and the scaled divisor.
    logic                     r6_v;
    logic signed [PP_W+1:0]   r6_pp [3][3][3][2];
    logic                     r6_found;
    logic                     r6_neg;
    logic [DEN_W-1:0]         r6_den;
    logic signed [IN_W+1:0]   n_sp [3][3];
    logic signed [IN_W:0]     n_cp [3][3][2];
    logic [DET_W-1:0]         n_abs_det;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            n_sp[p][0] = $signed({2'b00, r5_s[p][31:0]});
            n_sp[p][1] = $signed({2'b00, r5_s[p][63:32]});
            n_sp[p][2] = $signed(r5_s[p][S_W-1:64]);
            for (int k = 0; k < 3; k++) begin
                n_cp[p][k][0] = $signed({1'b0, r5_c[p][k][31:0]});
                n_cp[p][k][1] = $signed(r5_c[p][k][CR_W-1:32]);
            end
        end
        n_abs_det = (r5_det < 0) ? DET_W'(-r5_det) : DET_W'(r5_det);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                for (int a = 0; a < 3; a++) begin
                    for (int b = 0; b < 2; b++) begin
                        r6_pp[p][k][a][b] <= (PP_W+2)'(n_sp[p][a] * n_cp[p][k][b]);
                    end
                end
            end
        end
        r6_found <= (r5_det != '0) && (n_abs_det >= DET_W'(r_thr));
        r6_neg   <= r5_det < 0;
        r6_den   <= {n_abs_det, {FRAC_BITS{1'b0}}};
    end

    // Stage 7: one numerator term per plane and coordinate.
    logic                     r7_v;
    logic signed [NUM_W-1:0]  r7_t [3][3];
    logic                     r7_found;
    logic                     r7_neg;
    logic [DEN_W-1:0]         r7_den;
    logic signed [NUM_W-1:0]  n_t  [3][3];

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                n_t[p][k] = '0;
                for (int a = 0; a < 3; a++) begin
                    for (int b = 0; b < 2; b++) begin
                        n_t[p][k] = n_t[p][k] + (NUM_W'(r6_pp[p][k][a][b]) <<< (32 * (a + b)));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                r7_t[p][k] <= n_t[p][k];
            end
        end
        r7_found <= r6_found;
        r7_neg   <= r6_neg;
        r7_den   <= r6_den;
    end

    // Stage 8: numerator per coordinate.
    t_div_ctl                 r8_ctl;
    logic signed [NUM_W-1:0]  r8_num [3];
    logic [DEN_W-1:0]         r8_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_ctl <= '0;
        end else begin
            r8_ctl.valid <= r7_v;
            r8_ctl.found <= r7_found;
            r8_ctl.neg   <= r7_neg;
        end
        for (int k = 0; k < 3; k++) begin
            r8_num[k] <= r7_t[0][k] + r7_t[1][k] + r7_t[2][k];
        end
        r8_den <= r7_den;
    end

    // One divider per coordinate; the x lane carries the strobe and flag.
    logic ovf_x, ovf_y, ovf_z;

    tpi_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r8_ctl),
        .i_num   (r8_num[0]),
        .i_den   (r8_den),
        .o_valid (o_valid),
        .o_found (o_found),
        .o_q     (o_point_x),
        .o_ovf   (ovf_x)
    );

    tpi_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r8_ctl),
        .i_num   (r8_num[1]),
        .i_den   (r8_den),
        .o_valid (),
        .o_found (),
        .o_q     (o_point_y),
        .o_ovf   (ovf_y)
    );

    tpi_div u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r8_ctl),
        .i_num   (r8_num[2]),
        .i_den   (r8_den),
        .o_valid (),
        .o_found (),
        .o_q     (o_point_z),
        .o_ovf   (ovf_z)
    );

    assign o_overflowed = ovf_x | ovf_y | ovf_z;

endmodule

[src/tpi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_div
// Pipelined signed divide with saturation to a 32-bit result, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module tpi_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tpi_pkg::t_div_ctl                 i_ctl,
    input  logic signed [tpi_pkg::NUM_W-1:0]  i_num,
    input  logic        [tpi_pkg::DEN_W-1:0]  i_den,
    output logic                              o_valid,
    output logic                              o_found,
    output logic signed [tpi_pkg::QB-1:0]     o_q,
    output logic                              o_ovf
);
    import tpi_pkg::*;

    // Magnitude stage.
    t_div_ctl           r_a_ctl;
    logic [NUM_W-1:0]   r_a_mag;
    logic [DEN_W-1:0]   r_a_den;
    // Range check stage.
    t_div_ctl           r_b_ctl;
    logic               r_b_big;
    // Quotient stages; index 0 is the output of the range check.
    t_div_ctl           r_ctl [QB+1];
    logic               r_big [QB+1];
    logic [REM_W-1:0]   r_rem [QB+1];
    logic [DEN_W-1:0]   r_den [QB+1];
    logic [QB-1:0]      r_q   [QB+1];

    logic [NUM_W-1:0]   n_big_lim;
    logic [QB-1:0]      n_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else begin
            r_a_ctl.valid <= i_ctl.valid;
            r_a_ctl.found <= i_ctl.found;
            r_a_ctl.neg   <= (i_num != '0) && ((i_num < 0) != i_ctl.neg);
        end
        r_a_mag <= (i_num < 0) ? NUM_W'(-i_num) : NUM_W'(i_num);
        r_a_den <= i_den;
    end

    assign n_big_lim = NUM_W'({r_a_den, {QB{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= r_a_ctl;
        end
        r_big[0] <= (r_a_mag >= n_big_lim);
        r_rem[0] <= r_a_mag[REM_W-1:0];
        r_den[0] <= r_a_den;
        r_q[0]   <= '0;
    end

    // The stage for quotient bit i subtracts the divisor shifted by i.
    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int SH = QB - 1 - j;
        logic [REM_W-1:0] w_sub;
        assign w_sub = REM_W'(r_den[j]) << SH;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j+1] <= '0;
            end else begin
                r_ctl[j+1] <= r_ctl[j];
            end
            r_big[j+1] <= r_big[j];
            r_den[j+1] <= r_den[j];
            if (r_rem[j] >= w_sub) begin
                r_rem[j+1] <= r_rem[j] - w_sub;
                r_q[j+1]   <= r_q[j] | (QB'(1) << SH);
            end else begin
                r_rem[j+1] <= r_rem[j];
                r_q[j+1]   <= r_q[j];
            end
        end
    end

    assign n_q = r_q[QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            o_found <= 1'b0;
            o_ovf   <= 1'b0;
            o_q     <= '0;
        end else begin
            o_valid <= r_ctl[QB].valid;
            o_found <= r_ctl[QB].found;
            if (!r_ctl[QB].found) begin
                o_q   <= '0;
                o_ovf <= 1'b0;
            end else if (r_ctl[QB].neg) begin
                if (r_big[QB] || n_q > {1'b1, {(QB-1){1'b0}}}) begin
                    o_q   <= {1'b1, {(QB-1){1'b0}}};
                    o_ovf <= 1'b1;
                end else begin
                    o_q   <= -$signed(n_q);
                    o_ovf <= 1'b0;
                end
            end else begin
                if (r_big[QB] || n_q[QB-1]) begin
                    o_q   <= {1'b0, {(QB-1){1'b1}}};
                    o_ovf <= 1'b1;
                end else begin
                    o_q   <= $signed(n_q);
                    o_ovf <= 1'b0;
                end
            end
        end
    end

endmodule
